@@ hw/rtl/kvmp_pkg.sv @@
package kvmp_pkg;

    // Characters that the parser recognizes.
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    // Key lengths of the two recognized keys.
    localparam logic [3:0] CODE_KEY_LEN    = 4'd4;
    localparam logic [3:0] VERSION_KEY_LEN = 4'd7;
    localparam logic [3:0] KEY_POS_MAX     = 4'd8;

    // One input transaction.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_text;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic        marker_found;
        logic [31:0] code_value;
        logic [7:0]  version_char;
        logic        char_present;
        logic [4:0]  char_position;
        logic        run_last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;   // process the input byte of the accepted transaction
        logic close;  // close the open line at end of text
        logic rd;     // read the version store at the emission index
        logic load;   // load the output register
        logic adv;    // advance the emission index
        logic clear;  // return all parser state to its reset value
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register can take a new result this cycle
        logic last;      // the result being formed is the last of the run
    } t_status;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // Characters of the key "code".
    function automatic logic [7:0] code_key_char(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0: ch = 8'h63;
            2'd1: ch = 8'h6F;
            2'd2: ch = 8'h64;
            2'd3: ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Characters of the key "version".
    function automatic logic [7:0] version_key_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0: ch = 8'h76;
            3'd1: ch = 8'h65;
            3'd2: ch = 8'h72;
            3'd3: ch = 8'h73;
            3'd4: ch = 8'h69;
            3'd5: ch = 8'h6F;
            3'd6: ch = 8'h6E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ hw/rtl/kvmp_ctrl.sv @@
module kvmp_ctrl
    import kvmp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_end_of_text,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    typedef enum logic [1:0] {
        S_RUN,
        S_CLOSE,
        S_READ,
        S_LOAD
    } t_state;

    t_state r_state;

    // Sequencing of byte intake and the end-of-text emission run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            unique case (r_state)
                S_RUN: begin
                    if (i_in_valid && i_end_of_text) begin
                        r_state <= S_CLOSE;
                    end
                end
                S_CLOSE: begin
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (i_status.out_free) begin
                        r_state <= i_status.last ? S_RUN : S_READ;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    // Input transactions are taken only while bytes are being parsed.
    assign o_in_stall = (r_state != S_RUN);

    // Commands to the datapath follow the state.
    always_comb begin
        o_cmd       = '0;
        o_cmd.take  = (r_state == S_RUN) && i_in_valid;
        o_cmd.close = (r_state == S_CLOSE);
        o_cmd.rd    = (r_state == S_READ);
        if ((r_state == S_LOAD) && i_status.out_free) begin
            o_cmd.load  = 1'b1;
            o_cmd.clear = i_status.last;
            o_cmd.adv   = !i_status.last;
        end
    end

endmodule

@@ hw/rtl/kvmp_dp.sv @@
module kvmp_dp
    import kvmp_pkg::*;
#(
    parameter int VERSION_BYTES = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out
);

    localparam int CAP    = VERSION_BYTES - 1;
    localparam int DEPTH  = 2 * CAP;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W  = $clog2(VERSION_BYTES);
    localparam int PLEN_W = $clog2(VERSION_BYTES + 1);

    typedef enum logic [1:0] {
        PH_START,
        PH_KEY,
        PH_VALUE,
        PH_SKIP
    } t_phase;

    // Line parsing state.
    t_phase              r_phase, n_phase;
    logic [3:0]          r_key_pos, n_key_pos;
    logic                r_code_alive, n_code_alive;
    logic                r_ver_alive, n_ver_alive;
    logic                r_key_gap, n_key_gap;
    logic                r_is_code, n_is_code;
    logic                r_is_ver, n_is_ver;
    logic [31:0]         r_pnum, n_pnum;
    logic                r_num_nonempty, n_num_nonempty;
    logic                r_num_err, n_num_err;
    logic [PLEN_W-1:0]   r_plen, n_plen;
    logic [LEN_W-1:0]    r_ptrim, n_ptrim;
    logic                r_too_long, n_too_long;
    logic                r_vgap, n_vgap;

    // Results kept across lines.
    logic [31:0]         r_code, n_code;
    logic                r_code_seen, n_code_seen;
    logic [LEN_W-1:0]    r_slen, n_slen;
    logic                r_sel, n_sel;
    logic [LEN_W-1:0]    r_idx, n_idx;

    // Version store: two banks, one holds the accepted string, one takes the next.
    logic [7:0]          r_mem [DEPTH];
    logic [7:0]          r_mem_q;
    logic                mem_we;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;

    // Output register.
    logic                r_out_valid;
    t_out_item           r_out;
    t_out_item           out_next;

    logic [7:0]          c;
    logic                blank;
    logic                take;
    logic                line_close;
    logic                value_go;
    logic                num_err_t;
    logic [35:0]         prod;
    logic                single;
    logic                last;
    logic                out_free;

    // Key matcher outputs for the current byte.
    logic [3:0]          k_pos;
    logic                k_code_alive;
    logic                k_ver_alive;
    logic                k_gap;

    assign c     = i_in.data_byte;
    assign blank = is_blank(c);
    assign take  = i_cmd.take && i_in.byte_present;

    // The value starts at its first non-blank byte.
    assign value_go = !((r_plen == '0) && blank);

    // Decimal accumulation: times ten is two shifted adds.
    assign prod = ({4'b0, r_pnum} << 3) + ({4'b0, r_pnum} << 1) + {32'b0, c[3:0]};

    // Key matching against both candidate keys at once.
    always_comb begin
        k_pos        = r_key_pos;
        k_code_alive = r_code_alive;
        k_ver_alive  = r_ver_alive;
        k_gap        = r_key_gap;
        if (blank) begin
            k_gap = 1'b1;
        end else begin
            k_code_alive = r_code_alive && !r_key_gap && (r_key_pos < CODE_KEY_LEN)
                           && (code_key_char(r_key_pos[1:0]) == c);
            k_ver_alive  = r_ver_alive && !r_key_gap && (r_key_pos < VERSION_KEY_LEN)
                           && (version_key_char(r_key_pos[2:0]) == c);
            if (r_key_pos < KEY_POS_MAX) begin
                k_pos = r_key_pos + 4'd1;
            end
        end
    end

    // Next state of the parser.
    always_comb begin
        n_phase        = r_phase;
        n_key_pos      = r_key_pos;
        n_code_alive   = r_code_alive;
        n_ver_alive    = r_ver_alive;
        n_key_gap      = r_key_gap;
        n_is_code      = r_is_code;
        n_is_ver       = r_is_ver;
        n_pnum         = r_pnum;
        n_num_nonempty = r_num_nonempty;
        n_num_err      = r_num_err;
        n_plen         = r_plen;
        n_ptrim        = r_ptrim;
        n_too_long     = r_too_long;
        n_vgap         = r_vgap;
        n_code         = r_code;
        n_code_seen    = r_code_seen;
        n_slen         = r_slen;
        n_sel          = r_sel;
        num_err_t      = r_num_err;

        line_close = !i_cmd.clear && (i_cmd.close || (take && (c == CH_NL)));

        // A newline, end of text or the end of a run starts a fresh line.
        if (i_cmd.clear || line_close) begin
            n_phase        = PH_START;
            n_key_pos      = 4'd0;
            n_code_alive   = 1'b1;
            n_ver_alive    = 1'b1;
            n_key_gap      = 1'b0;
            n_is_code      = 1'b0;
            n_is_ver       = 1'b0;
            n_pnum         = 32'd0;
            n_num_nonempty = 1'b0;
            n_num_err      = 1'b0;
            n_plen         = '0;
            n_ptrim        = '0;
            n_too_long     = 1'b0;
            n_vgap         = 1'b0;
        end

        if (i_cmd.clear) begin
            n_code      = 32'd0;
            n_code_seen = 1'b0;
            n_slen      = '0;
            n_sel       = 1'b0;
        end else if (line_close) begin
            // Commit a well-formed value of a recognized key.
            if (r_phase == PH_VALUE) begin
                if (r_is_code && r_num_nonempty && !r_num_err) begin
                    n_code      = r_pnum;
                    n_code_seen = 1'b1;
                end else if (r_is_ver && !r_too_long) begin
                    n_sel  = !r_sel;
                    n_slen = r_ptrim;
                end
            end
        end else if (take) begin
            unique case (r_phase)
                PH_START: begin
                    if (!blank) begin
                        if (c == CH_HASH) begin
                            n_phase = PH_SKIP;
                        end else if (c == CH_EQ) begin
                            n_phase = PH_VALUE;
                        end else begin
                            n_phase      = PH_KEY;
                            n_key_pos    = k_pos;
                            n_code_alive = k_code_alive;
                            n_ver_alive  = k_ver_alive;
                            n_key_gap    = k_gap;
                        end
                    end
                end
                PH_KEY: begin
                    if (c == CH_EQ) begin
                        n_is_code = r_code_alive && (r_key_pos == CODE_KEY_LEN);
                        n_is_ver  = r_ver_alive && (r_key_pos == VERSION_KEY_LEN);
                        n_phase   = PH_VALUE;
                    end else begin
                        n_key_pos    = k_pos;
                        n_code_alive = k_code_alive;
                        n_ver_alive  = k_ver_alive;
                        n_key_gap    = k_gap;
                    end
                end
                PH_VALUE: begin
                    if (value_go) begin
                        if (blank) begin
                            n_vgap = 1'b1;
                        end else begin
                            num_err_t      = r_num_err || r_vgap || !is_digit(c);
                            n_num_nonempty = 1'b1;
                            if (!num_err_t) begin
                                n_pnum    = prod[31:0];
                                num_err_t = (prod[35:32] != 4'd0);
                            end
                            n_num_err = num_err_t;
                            if (r_plen >= PLEN_W'(CAP)) begin
                                n_too_long = 1'b1;
                            end else begin
                                n_ptrim = LEN_W'(r_plen) + LEN_W'(1);
                            end
                        end
                        if (r_plen < PLEN_W'(VERSION_BYTES)) begin
                            n_plen = r_plen + PLEN_W'(1);
                        end
                    end
                end
                PH_SKIP: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Version bytes go into the bank that is not currently accepted.
    assign mem_we  = take && (c != CH_NL) && (r_phase == PH_VALUE) && value_go
                     && r_is_ver && (r_plen < PLEN_W'(CAP));
    assign wr_addr = (r_sel ? ADDR_W'(0) : ADDR_W'(CAP)) + ADDR_W'(r_plen);
    assign rd_addr = (r_sel ? ADDR_W'(CAP) : ADDR_W'(0)) + ADDR_W'(r_idx);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= c;
        end
        if (i_cmd.rd) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    // Emission index within the run.
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.clear) begin
            n_idx = '0;
        end else if (i_cmd.adv) begin
            n_idx = r_idx + LEN_W'(1);
        end
    end

    // Parser registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_START;
            r_key_pos      <= 4'd0;
            r_code_alive   <= 1'b1;
            r_ver_alive    <= 1'b1;
            r_key_gap      <= 1'b0;
            r_is_code      <= 1'b0;
            r_is_ver       <= 1'b0;
            r_pnum         <= 32'd0;
            r_num_nonempty <= 1'b0;
            r_num_err      <= 1'b0;
            r_plen         <= '0;
            r_ptrim        <= '0;
            r_too_long     <= 1'b0;
            r_vgap         <= 1'b0;
            r_code         <= 32'd0;
            r_code_seen    <= 1'b0;
            r_slen         <= '0;
            r_sel          <= 1'b0;
            r_idx          <= '0;
        end else begin
            r_phase        <= n_phase;
            r_key_pos      <= n_key_pos;
            r_code_alive   <= n_code_alive;
            r_ver_alive    <= n_ver_alive;
            r_key_gap      <= n_key_gap;
            r_is_code      <= n_is_code;
            r_is_ver       <= n_is_ver;
            r_pnum         <= n_pnum;
            r_num_nonempty <= n_num_nonempty;
            r_num_err      <= n_num_err;
            r_plen         <= n_plen;
            r_ptrim        <= n_ptrim;
            r_too_long     <= n_too_long;
            r_vgap         <= n_vgap;
            r_code         <= n_code;
            r_code_seen    <= n_code_seen;
            r_slen         <= n_slen;
            r_sel          <= n_sel;
            r_idx          <= n_idx;
        end
    end

    // A run without a code or without a version is a single bare result.
    assign single = !r_code_seen || (r_slen == '0);
    assign last   = single || (({1'b0, r_idx} + {{LEN_W{1'b0}}, 1'b1}) == {1'b0, r_slen});

    always_comb begin
        out_next.marker_found  = r_code_seen;
        out_next.code_value    = r_code_seen ? r_code : 32'd0;
        out_next.version_char  = single ? 8'h00 : r_mem_q;
        out_next.char_present  = !single;
        out_next.char_position = single ? 5'd0 : 5'(r_idx);
        out_next.run_last      = last;
    end

    // Output register: holds a result until the consumer takes it.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= out_next;
        end
    end

    assign o_status.out_free = out_free;
    assign o_status.last     = last;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

endmodule

@@ hw/rtl/key_value_marker_parser_top.sv @@
// Key/value marker parser. The block takes a text one byte per input transaction, at one
// transaction per cycle while o_in_stall is low, and tracks the lines "code = <decimal>" and
// "version = <string>" (keys and values trimmed of space, tab and CR, the last acceptable
// line of each key wins). A transaction with end_of_text set closes the text: the input
// then stalls while the open line is committed and, for each result, the version store is
// read and the output register loaded, also while the consumer stalls the output.
// The run gives one result per version character, or a single result when no code or no
// version was found, and the last result carries run_last. The version store is a
// double-banked memory of 2*(VERSION_BYTES-1) bytes; a version longer than VERSION_BYTES-1
// bytes is dropped. After the last result is loaded, all state is back at reset and the
// next text can start while that result still waits to be taken.
module key_value_marker_parser_top
    import kvmp_pkg::*;
#(
    parameter int VERSION_BYTES = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    t_cmd    cmd;
    t_status status;

    // Sequencer for byte intake and the emission run.
    kvmp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_end_of_text (i_in.end_of_text),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_in_stall    (o_in_stall)
    );

    // Line parser, version store and output register.
    kvmp_dp #(
        .VERSION_BYTES (VERSION_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

@@ hw/rtl/kvmp_checker.sv @@
module kvmp_checker
    import kvmp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);

    // A stalled result transaction holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // A result without a character is the only and last result of its run.
    a_bare_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.char_present |->
            o_out.run_last && (o_out.version_char == 8'h00) && (o_out.char_position == 5'd0))
        else $error("bare result not final or not zeroed");

    // Without a found code the result reads zero and carries no version.
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.marker_found |->
            (o_out.code_value == 32'd0) && !o_out.char_present)
        else $error("result without code is not zero");

    // The end of a text starts the emission run, during which no byte is taken.
    a_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.end_of_text |=> o_in_stall)
        else $error("input taken right after end of text");

endmodule

bind key_value_marker_parser_top kvmp_checker u_kvmp_checker (.*);
